// ===== rtl/csrmm_pkg.sv =====
// Shared types and constants for the sparse row matrix multiplier.
`default_nettype none
package csrmm_pkg;

	// Function codes of an input word
	localparam logic [1:0] FUNC_LOAD_PTR = 2'd0;
	localparam logic [1:0] FUNC_LOAD_ENT = 2'd1;
	localparam logic [1:0] FUNC_A_ENTRY  = 2'd2;

	// End-of-list mark for the touched column list
	localparam logic [6:0] LINK_END = 7'd64;

	typedef struct packed {
		logic [1:0]        func;
		logic [9:0]        slot;
		logic [10:0]       pointer;
		logic [5:0]        column;
		logic signed [7:0] value;
		logic              has_entry;
		logic              row_end;
	} item_t;

	typedef struct packed {
		logic              entry_valid;
		logic [5:0]        out_column;
		logic signed [7:0] out_value;
		logic              last_of_row;
		logic [23:0]       nnz_total;
	} result_t;

	// Access to the B store: one port per memory, read or write in a cycle
	typedef struct packed {
		logic        ptr_we;
		logic        ptr_re;
		logic [10:0] ptr_addr;
		logic [10:0] ptr_wdata;
		logic        ent_we;
		logic        ent_re;
		logic [10:0] ent_addr;
		logic [5:0]  ent_wcol;
		logic [7:0]  ent_wval;
	} bst_req_t;

	// Access to the accumulator and link store
	typedef struct packed {
		logic       re;
		logic       acc_we;
		logic       link_we;
		logic       set_touch;
		logic       clr_touch;
		logic [5:0] addr;
		logic [7:0] acc_wdata;
		logic [6:0] link_wdata;
	} acc_req_t;

	typedef struct packed {
		logic       touched;
		logic [7:0] acc;
		logic [6:0] link;
	} acc_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/csrmm_bstore.sv =====
// B matrix store: row start pointers and entries (column, value).
`default_nettype none
module csrmm_bstore #(
	parameter int B_ROWS = 64,
	parameter int B_NNZ  = 1024
) (
	input  wire                   clk,
	input  csrmm_pkg::bst_req_t   req,
	output logic [10:0]           ptr_rdata,
	output logic [5:0]            ent_rcol,
	output logic [7:0]            ent_rval
);
	import csrmm_pkg::*;

	localparam int PTR_DEPTH = B_ROWS + 1;
	localparam int PTR_AW    = $clog2(PTR_DEPTH);
	localparam int ENT_DEPTH = (B_NNZ < 1024) ? B_NNZ : 1024;
	localparam int ENT_AW    = (ENT_DEPTH > 1) ? $clog2(ENT_DEPTH) : 1;

	logic [10:0] ptr_mem [PTR_DEPTH];
	logic [13:0] ent_mem [ENT_DEPTH];

	always_ff @(posedge clk) begin
		if (req.ptr_we) begin
			ptr_mem[req.ptr_addr[PTR_AW-1:0]] <= req.ptr_wdata;
		end else if (req.ptr_re) begin
			ptr_rdata <= ptr_mem[req.ptr_addr[PTR_AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (req.ent_we) begin
			ent_mem[req.ent_addr[ENT_AW-1:0]] <= {req.ent_wcol, req.ent_wval};
		end else if (req.ent_re) begin
			{ent_rcol, ent_rval} <= ent_mem[req.ent_addr[ENT_AW-1:0]];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/csrmm_accstore.sv =====
// Per-column accumulator and link memories with touched flags.
`default_nettype none
module csrmm_accstore #(
	parameter int COLS = 64
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  csrmm_pkg::acc_req_t   req,
	output csrmm_pkg::acc_rsp_t   rsp
);
	import csrmm_pkg::*;

	localparam int CW = $clog2(COLS);

	logic [7:0]      acc_mem  [COLS];
	logic [6:0]      link_mem [COLS];
	logic [COLS-1:0] touched_q;
	logic [CW-1:0]   idx;

	assign idx = req.addr[CW-1:0];

	always_ff @(posedge clk) begin
		if (req.acc_we) begin
			acc_mem[idx] <= req.acc_wdata;
		end
		if (req.link_we) begin
			link_mem[idx] <= req.link_wdata;
		end
		if (req.re) begin
			rsp.acc     <= acc_mem[idx];
			rsp.link    <= link_mem[idx];
			rsp.touched <= touched_q[idx];
		end
	end

	// touched flags; an untouched column's acc and link are stale, marked by touched = 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			touched_q <= '0;
		end else begin
			if (req.set_touch) begin
				touched_q[idx] <= 1'b1;
			end else if (req.clr_touch) begin
				touched_q[idx] <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/sparse_row_matrix_multiply.sv =====
// Top level of the sparse row matrix multiplier (row-wise accumulation).
//
// Input channel item/item_valid/item_stall carries one word per item. Func 0
// writes a B row start pointer and func 1 a B entry. Func 2
// carries an A nonzero (column j, value) and/or the end of the current A row.
// Output channel result/result_valid/result_stall carries C nonzeros in reverse
// order of first touch, the last one of a row flagged; an empty row gives one
// marker word. nnz_total is the running nonzero count, modulo 2^24.
//
// Sequence: an A entry fetches its B row bounds, then walks each B entry: entry
// read, accumulator read, accumulator write back through the single port of each
// memory; an entry whose column is out of range is skipped after its read. A row
// end reads and drains each touched column in turn, then gives the final word.
// item_stall is high while bounds are fetched or a walk or drain is under way.
// One nonzero is held back so the row's final word can be flagged; the output
// register lets the drain continue while the receiver stalls, until a second
// word is due, then the drain holds. Reset clears the touched flags, the list
// head and the count; B contents are undefined until loaded.
`default_nettype none
module sparse_row_matrix_multiply #(
	parameter int COLS   = 64,
	parameter int B_ROWS = 64,
	parameter int B_NNZ  = 1024
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  item_valid,
	output logic                 item_stall,
	input  csrmm_pkg::item_t     item,
	output logic                 result_valid,
	input  wire                  result_stall,
	output csrmm_pkg::result_t   result
);
	import csrmm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_PTR1, S_PTR2, S_WRD, S_WEN, S_WACC, S_DRD, S_DDAT, S_DEND
	} state_t;

	state_t      state_q;
	logic [9:0]  j_q;
	logic [7:0]  a_val_q;
	logic        row_end_q;
	logic [10:0] kk_q;
	logic [10:0] end_q;
	logic [7:0]  product_q;
	logic [5:0]  col_q;
	logic [6:0]  head_q;
	logic [23:0] nnz_q;
	logic        pend_v_q;
	logic [5:0]  pend_col_q;
	logic [7:0]  pend_val_q;
	logic [23:0] pend_cnt_q;

	bst_req_t    breq;
	acc_req_t    areq;
	acc_rsp_t    arsp;
	logic [10:0] ptr_rdata;
	logic [5:0]  ent_rcol;
	logic [7:0]  ent_rval;

	logic        accept;
	logic        out_free;
	logic        walk_more;
	logic        col_ok;
	logic        drain_go;
	logic        emit;
	logic [7:0]  sum;

	assign item_stall = (state_q != S_IDLE);
	assign accept     = item_valid && !item_stall;
	assign out_free   = !result_valid || !result_stall;
	assign walk_more  = (kk_q < end_q) && ({6'd0, kk_q} < 17'(B_NNZ));
	assign col_ok     = {1'b0, ent_rcol} < 7'(COLS);
	assign drain_go   = (arsp.acc == 8'd0) || !pend_v_q || out_free;
	assign sum        = arsp.touched ? 8'(arsp.acc + product_q) : product_q;
	// a word is loaded into the output register this cycle
	assign emit       = ((state_q == S_DDAT) && drain_go && (arsp.acc != 8'd0) && pend_v_q)
			|| ((state_q == S_DEND) && out_free);

	// Memory requests
	always_comb begin
		breq = '0;
		areq = '0;
		case (state_q)
			S_IDLE: begin
				if (accept && item.func == FUNC_LOAD_PTR
						&& {1'b0, item.slot} <= 11'(B_ROWS)) begin
					breq.ptr_we    = 1'b1;
					breq.ptr_addr  = {1'b0, item.slot};
					breq.ptr_wdata = item.pointer;
				end
				if (accept && item.func == FUNC_LOAD_ENT
						&& {7'd0, item.slot} < 17'(B_NNZ)) begin
					breq.ent_we   = 1'b1;
					breq.ent_addr = {1'b0, item.slot};
					breq.ent_wcol = item.column;
					breq.ent_wval = item.value;
				end
				if (accept && item.func == FUNC_A_ENTRY) begin
					breq.ptr_re   = 1'b1;
					breq.ptr_addr = {1'b0, item.slot};
				end
			end
			S_PTR1: begin
				breq.ptr_re   = 1'b1;
				breq.ptr_addr = 11'({1'b0, j_q} + 11'd1);
			end
			S_WRD: begin
				breq.ent_re   = walk_more;
				breq.ent_addr = kk_q;
			end
			S_WEN: begin
				areq.re   = col_ok;
				areq.addr = ent_rcol;
			end
			S_WACC: begin
				areq.addr       = col_q;
				areq.acc_we     = 1'b1;
				areq.acc_wdata  = sum;
				areq.link_we    = !arsp.touched;
				areq.set_touch  = !arsp.touched;
				areq.link_wdata = head_q;
			end
			S_DRD: begin
				areq.re   = (head_q != LINK_END);
				areq.addr = head_q[5:0];
			end
			S_DDAT: begin
				areq.addr      = head_q[5:0];
				areq.clr_touch = drain_go;
			end
			default: begin
			end
		endcase
	end

	csrmm_bstore #(.B_ROWS(B_ROWS), .B_NNZ(B_NNZ)) u_bstore (
		.clk      (clk),
		.req      (breq),
		.ptr_rdata(ptr_rdata),
		.ent_rcol (ent_rcol),
		.ent_rval (ent_rval)
	);

	csrmm_accstore #(.COLS(COLS)) u_accstore (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (areq),
		.rsp   (arsp)
	);

	// Sequencer, held-back word and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= LINK_END;
			nnz_q        <= '0;
			pend_v_q     <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			if (result_valid && !result_stall && !emit) begin
				result_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept && item.func == FUNC_A_ENTRY) begin
						j_q       <= item.slot;
						a_val_q   <= item.value;
						row_end_q <= item.row_end;
						if (item.has_entry && {1'b0, item.slot} < 11'(B_ROWS)) begin
							state_q <= S_PTR1;
						end else if (item.row_end) begin
							state_q <= S_DRD;
						end
					end
				end
				S_PTR1: begin
					kk_q    <= ptr_rdata;
					state_q <= S_PTR2;
				end
				S_PTR2: begin
					end_q   <= ptr_rdata;
					state_q <= S_WRD;
				end
				S_WRD: begin
					if (walk_more) begin
						state_q <= S_WEN;
					end else if (row_end_q) begin
						state_q <= S_DRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_WEN: begin
					if (col_ok) begin
						product_q <= 8'(a_val_q * ent_rval);
						col_q     <= ent_rcol;
						state_q   <= S_WACC;
					end else begin
						kk_q    <= 11'(kk_q + 11'd1);
						state_q <= S_WRD;
					end
				end
				S_WACC: begin
					if (!arsp.touched) begin
						head_q <= {1'b0, col_q};
					end
					kk_q    <= 11'(kk_q + 11'd1);
					state_q <= S_WRD;
				end
				S_DRD: begin
					state_q <= (head_q == LINK_END) ? S_DEND : S_DDAT;
				end
				S_DDAT: begin
					// hold while a second word would overrun the output register
					if (drain_go) begin
						if (arsp.acc != 8'd0) begin
							nnz_q      <= 24'(nnz_q + 24'd1);
							pend_v_q   <= 1'b1;
							pend_col_q <= head_q[5:0];
							pend_val_q <= arsp.acc;
							pend_cnt_q <= 24'(nnz_q + 24'd1);
							if (pend_v_q) begin
								result_valid       <= 1'b1;
								result.entry_valid <= 1'b1;
								result.out_column  <= pend_col_q;
								result.out_value   <= pend_val_q;
								result.last_of_row <= 1'b0;
								result.nnz_total   <= pend_cnt_q;
							end
						end
						head_q  <= arsp.link;
						state_q <= S_DRD;
					end
				end
				S_DEND: begin
					if (out_free) begin
						result_valid       <= 1'b1;
						result.entry_valid <= pend_v_q;
						result.out_column  <= pend_v_q ? pend_col_q : 6'd0;
						result.out_value   <= pend_v_q ? pend_val_q : 8'd0;
						result.last_of_row <= 1'b1;
						result.nnz_total   <= pend_v_q ? pend_cnt_q : nnz_q;
						pend_v_q           <= 1'b0;
						head_q             <= LINK_END;
						state_q            <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
